// File: sv/fpcc_pkg.sv
`default_nettype none

package fpcc_pkg;

  localparam int unsigned FLASH_BYTES = 131072;
  localparam int unsigned PAGE_BYTES  = 128;
  localparam int unsigned FA_AW       = $clog2(FLASH_BYTES);
  localparam int unsigned PB_AW       = $clog2(PAGE_BYTES);
  localparam int unsigned PG_W        = FA_AW - PB_AW;

  localparam logic [2:0] ACT_STATUS_RD = 3'd0;
  localparam logic [2:0] ACT_CMD_WR    = 3'd1;
  localparam logic [2:0] ACT_CMD_RD    = 3'd2;
  localparam logic [2:0] ACT_PB_LOAD   = 3'd3;
  localparam logic [2:0] ACT_DATA_RD   = 3'd4;

  localparam logic [7:0] OP_SELECT   = 8'h4b;
  localparam logic [7:0] OP_ERASE    = 8'h78;
  localparam logic [7:0] OP_SEL_STAT = 8'ha5;
  localparam logic [7:0] OP_WRITE    = 8'hb4;
  localparam logic [7:0] OP_EXEC     = 8'hd2;
  localparam logic [7:0] OP_STATUS   = 8'he1;
  localparam logic [7:0] OP_READ     = 8'hf0;

  localparam logic [63:0] STAT_ERASE    = 64'h1111800800c20000;
  localparam logic [63:0] STAT_SEL      = 64'h1111800400c20000;
  localparam logic [63:0] STAT_STATUS   = 64'h1111800100c20000;
  localparam logic [63:0] STAT_READ     = 64'h11118004f0000000;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_ERASE  = 3'd1,
    MODE_WRITE  = 3'd2,
    MODE_READ   = 3'd3,
    MODE_STATUS = 3'd4
  } mode_e;

  // fields from the lowest bit up: reg_offset, command, byte_index,
  // data_byte, cart_base, dma_index
  typedef struct packed {
    logic [16:0] dma_index;
    logic [15:0] cart_base;
    logic [7:0]  data_byte;
    logic [6:0]  byte_index;
    logic [31:0] command;
    logic [15:0] reg_offset;
  } in_item_t;

endpackage

`default_nettype wire

// File: sv/flash_page_command_controller.sv
// channel    | group          | payload
// -----------+----------------+-------------------------------------------
// request    | s_axis_*       | tuser action, tdata access fields (96 bits)
// response   | m_axis_*       | tdata read_value (32 bits)
// config     | cfg_we/wdata   | device_enabled
//
// an item that returns data passes through ST_EMIT, which also waits on m_axis_tready
// an item without a result completes in ST_IDLE
// an execute that erases or programs walks the page in ST_PROG, then ST_DRAIN,
//   one byte at a time through the single write port of the flash memory
// after reset a clearing pass over every flash address fills flash with 0xff
//   and the page buffer with zeros; s_axis_tready stays low meanwhile
// a result waiting on m_axis does not block the next request transfer
`default_nettype none

module flash_page_command_controller
  import fpcc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // reg_offset, command, byte_index, data_byte, cart_base, dma_index
  input  wire logic [95:0] s_axis_tdata,
  // action
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_value
  output logic [31:0]      m_axis_tdata
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EMIT  = 5'b00100,
    ST_PROG  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic [63:0]       status_q, status_d;
  logic [PG_W-1:0]   page_q, page_d;
  logic              dev_en_q;
  logic              erase_q, erase_d;
  logic [PB_AW-1:0]  prog_cnt_q, prog_cnt_d;
  logic [FA_AW-1:0]  clr_q, clr_d;
  logic [31:0]       pend_q, pend_d;
  logic              pend_mem_q, pend_mem_d;
  logic              wr_v_q;
  logic [PB_AW-1:0]  wr_off_q;
  logic              out_v_q, out_v_d;
  logic [31:0]       out_data_q, out_data_d;

  logic [7:0]        flash_mem [FLASH_BYTES];
  logic [7:0]        page_mem [PAGE_BYTES];
  logic              fa_we, fa_re;
  logic [FA_AW-1:0]  fa_waddr, fa_raddr;
  logic [7:0]        fa_wdata, fa_rdata_q;
  logic              pb_we, pb_re;
  logic [PB_AW-1:0]  pb_waddr, pb_raddr;
  logic [7:0]        pb_wdata, pb_rdata_q;

  in_item_t          in_item;
  logic              in_fire;
  logic              reg_ok;

  assign in_item       = in_item_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign reg_ok        = dev_en_q && (in_item.reg_offset == '0);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  // data read address wraps over the device
  assign fa_raddr = FA_AW'({in_item.cart_base, 1'b0}) + FA_AW'(in_item.dma_index);

  assign fa_we    = (state_q == ST_CLEAR) || wr_v_q;
  assign fa_waddr = (state_q == ST_CLEAR) ? clr_q : {page_q, wr_off_q};
  assign fa_wdata = ((state_q == ST_CLEAR) || erase_q) ? 8'hff : pb_rdata_q;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    status_d   = status_q;
    page_d     = page_q;
    erase_d    = erase_q;
    prog_cnt_d = prog_cnt_q;
    clr_d      = clr_q;
    pend_d     = pend_q;
    pend_mem_d = pend_mem_q;
    pb_we      = 1'b0;
    pb_waddr   = in_item.byte_index[PB_AW-1:0];
    pb_wdata   = in_item.data_byte;
    pb_re      = 1'b0;
    pb_raddr   = prog_cnt_q;
    fa_re      = 1'b0;
    out_v_d    = out_v_q && !m_axis_tready;
    out_data_d = out_data_q;

    case (state_q)
      ST_CLEAR: begin
        pb_we    = 1'b1;
        pb_waddr = clr_q[PB_AW-1:0];
        pb_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            ACT_STATUS_RD: begin
              if (reg_ok) begin
                pend_d     = status_q[63:32];
                pend_mem_d = 1'b0;
                state_d    = ST_EMIT;
              end
            end
            ACT_CMD_WR: begin
              if (reg_ok) begin
                case (in_item.command[31:24])
                  OP_SELECT: begin
                    page_d = in_item.command[PG_W-1:0];
                  end
                  OP_ERASE: begin
                    mode_d   = MODE_ERASE;
                    status_d = STAT_ERASE;
                  end
                  OP_SEL_STAT: begin
                    page_d   = in_item.command[PG_W-1:0];
                    status_d = STAT_SEL;
                  end
                  OP_WRITE: begin
                    mode_d = MODE_WRITE;
                  end
                  OP_EXEC: begin
                    mode_d = MODE_IDLE;
                    if (mode_q inside {MODE_ERASE, MODE_WRITE}) begin
                      erase_d    = (mode_q == MODE_ERASE);
                      prog_cnt_d = '0;
                      state_d    = ST_PROG;
                    end
                  end
                  OP_STATUS: begin
                    mode_d   = MODE_STATUS;
                    status_d = STAT_STATUS;
                  end
                  OP_READ: begin
                    mode_d   = MODE_READ;
                    status_d = STAT_READ;
                  end
                  default: ;
                endcase
              end
            end
            ACT_CMD_RD: begin
              pend_d     = '0;
              pend_mem_d = 1'b0;
              state_d    = ST_EMIT;
            end
            ACT_PB_LOAD: begin
              pb_we = (mode_q == MODE_WRITE);
            end
            ACT_DATA_RD: begin
              if (mode_q == MODE_READ) begin
                fa_re      = 1'b1;
                pend_mem_d = 1'b1;
                state_d    = ST_EMIT;
              end else if ((mode_q == MODE_STATUS) && (in_item.dma_index < 17'd8)) begin
                pend_d     = {24'b0, status_q[{~in_item.dma_index[2:0], 3'b000} +: 8]};
                pend_mem_d = 1'b0;
                state_d    = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d    = 1'b1;
          out_data_d = pend_mem_q ? {24'b0, fa_rdata_q} : pend_q;
          state_d    = ST_IDLE;
        end
      end
      ST_PROG: begin
        pb_re      = 1'b1;
        prog_cnt_d = prog_cnt_q + 1'b1;
        if (&prog_cnt_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      mode_q   <= MODE_IDLE;
      status_q <= '0;
      page_q   <= '0;
      dev_en_q <= 1'b1;
      clr_q    <= '0;
      wr_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      status_q <= status_d;
      page_q   <= page_d;
      clr_q    <= clr_d;
      wr_v_q   <= (state_q == ST_PROG);
      out_v_q  <= out_v_d;
      if (cfg_we_i) begin
        dev_en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    erase_q    <= erase_d;
    prog_cnt_q <= prog_cnt_d;
    pend_q     <= pend_d;
    pend_mem_q <= pend_mem_d;
    wr_off_q   <= prog_cnt_q;
    out_data_q <= out_data_d;
  end

  // flash array, one write and one read port
  always_ff @(posedge clk_i) begin
    if (fa_we) begin
      flash_mem[fa_waddr] <= fa_wdata;
    end
    if (fa_re) begin
      fa_rdata_q <= flash_mem[fa_raddr];
    end
  end

  // page buffer
  always_ff @(posedge clk_i) begin
    if (pb_we) begin
      page_mem[pb_waddr] <= pb_wdata;
    end
    if (pb_re) begin
      pb_rdata_q <= page_mem[pb_raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/fpcc_checker.sv
`default_nettype none

module fpcc_checker
  import fpcc_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [2:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // nothing moves once reset has been seen
  assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid && !s_axis_tready)
    else $error("activity during reset");

  // a command read blocks the next request while its result is formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_CMD_RD) |=> !s_axis_tready)
    else $error("request taken while result pending");

  // a command read with a free output returns zero by way of ST_EMIT
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_CMD_RD)
      && !(m_axis_tvalid && !m_axis_tready)
    |=> ##1 m_axis_tvalid && (m_axis_tdata == 32'd0))
    else $error("command read result missing or nonzero");

endmodule

bind flash_page_command_controller fpcc_checker u_fpcc_checker (.*);

`default_nettype wire
